### src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, muted while reset is held.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/nfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_pkg
// Types and constants for the NFA word acceptor.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int CMD_W      = 2;
    localparam int STATE_IN_W = 4;
    localparam int SYM_IN_W   = 8;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_SYMBOL   = 2'd1,
        CMD_END_WORD = 2'd2,
        CMD_RSVD     = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 1'b0,
        CFG_FINAL_MASK  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_WR,
        S_SCAN,
        S_SCAN_DONE,
        S_EMIT
    } t_state;

endpackage

### src/nfa_word_acceptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_word_acceptor
// NFA acceptor by state-set simulation over a destination-mask memory.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                   tuser
//  s_axis    in   from_state, to_state, symbol         command
//  m_axis    out  accepted, final_active_set, pad      -
//  cfg       in   i_cfg_idx 0 start_state, 1 final_mask (i_cfg_data)
//
//  Add edge: memory read, then read-modify-write.
//  Symbol: one transition memory read per state.
//  End of word: waits while the result register is still full.
//  After reset the transition memory is swept to zero, one entry a cycle,
//  over all NUM_STATES rounded up to a power of two times 2**SYMBOL_BITS
//  entries (4096 at the defaults); no word is taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfa_word_acceptor #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nfa_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // from[3:0] to[7:4] symbol[15:8]
    input  logic [nfa_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // command[1:0]
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nfa_pkg::M_TDATA_W-1:0]   m_axis_tdata   // accepted[0] active_set[16:1]
);
    import nfa_pkg::*;

    localparam int STB = $clog2(NUM_STATES);
    localparam int AW  = STB + SYMBOL_BITS;
    localparam int DEPTH = 1 << AW;
    localparam int OUT_W = MASK_W + 1;

    logic [NUM_STATES-1:0] mem [DEPTH];

    t_state                 r_state, n_state;
    logic [STB-1:0]         r_scan, n_scan;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic [AW-1:0]          r_add_addr;
    logic [NUM_STATES-1:0]  r_add_hot;
    logic [AW-1:0]          r_clr;
    logic [NUM_STATES-1:0]  r_rd_data;
    logic                   r_rd_vld;
    logic                   r_rd_act;
    logic [NUM_STATES-1:0]  r_acc;
    logic [NUM_STATES-1:0]  r_active;
    logic [STATE_IN_W-1:0]  r_start;
    logic [MASK_W-1:0]      r_final;
    logic                   r_out_vld;
    logic [OUT_W-1:0]       r_out_data;

    t_cmd                   w_cmd;
    logic [STATE_IN_W-1:0]  w_from, w_to;
    logic [SYMBOL_BITS-1:0] w_sym;
    logic                   w_in_acc;
    logic                   w_edge_ok;
    logic                   w_emit;
    logic [AW-1:0]          w_rd_addr;
    logic                   w_mem_we;
    logic [AW-1:0]          w_wr_addr;
    logic [NUM_STATES-1:0]  w_wr_data;
    logic [NUM_STATES-1:0]  w_acc_sum;
    logic [NUM_STATES-1:0]  w_start_hot;
    logic [MASK_W-1:0]      w_active16;

    function automatic logic [NUM_STATES-1:0] f_hot(input logic [STATE_IN_W-1:0] idx);
        logic [NUM_STATES-1:0] v;
        v = '0;
        if (idx < NUM_STATES) begin
            v = NUM_STATES'(1) << idx;
        end
        return v;
    endfunction

    assign w_cmd       = t_cmd'(s_axis_tuser[CMD_W-1:0]);
    assign w_from      = s_axis_tdata[3:0];
    assign w_to        = s_axis_tdata[7:4];
    assign w_sym       = s_axis_tdata[8 +: SYMBOL_BITS];
    assign w_edge_ok   = (w_from < NUM_STATES) && (w_to < NUM_STATES);
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_start_hot = f_hot(r_start);
    assign w_active16  = MASK_W'(r_active);
    assign w_acc_sum   = r_acc | ((r_rd_vld && r_rd_act) ? r_rd_data : '0);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_TDATA_W'(r_out_data);

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        n_scan    = r_scan;
        w_emit    = 1'b0;
        w_mem_we  = 1'b0;
        w_wr_addr = r_add_addr;
        w_wr_data = r_rd_data | r_add_hot;
        w_rd_addr = {r_sym, r_scan};
        unique case (r_state)
            S_CLEAR: begin
                w_mem_we  = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_rd_addr = {w_sym, STB'(w_from)};
                if (w_in_acc) begin
                    unique case (w_cmd)
                        CMD_ADD_EDGE: if (w_edge_ok) n_state = S_ADD_WR;
                        CMD_SYMBOL:   n_state = S_SCAN;
                        CMD_END_WORD: n_state = S_EMIT;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_WR: begin
                w_mem_we = 1'b1;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (r_scan == STB'(NUM_STATES - 1)) begin
                    n_scan  = '0;
                    n_state = S_SCAN_DONE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_SCAN_DONE: begin
                n_state = S_IDLE;
            end
            S_EMIT: begin
                w_emit = !r_out_vld || m_axis_tready;
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // transition memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_scan    <= '0;
            r_clr     <= '0;
            r_rd_vld  <= 1'b0;
            r_active  <= NUM_STATES'(1);
            r_start   <= '0;
            r_final   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_rd_vld <= (r_state == S_SCAN);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_SCAN_DONE) begin
                r_active <= w_acc_sum;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
                r_active  <= w_start_hot;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_START_STATE: begin
                        r_start  <= i_cfg_data[STATE_IN_W-1:0];
                        r_active <= f_hot(i_cfg_data[STATE_IN_W-1:0]);
                    end
                    CFG_FINAL_MASK: r_final <= i_cfg_data[MASK_W-1:0];
                    default: r_final <= r_final;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sym      <= w_sym;
            r_add_addr <= {w_sym, STB'(w_from)};
            r_add_hot  <= NUM_STATES'(1) << w_to;
            r_acc      <= '0;
        end else if (r_state == S_SCAN) begin
            r_acc <= w_acc_sum;
        end
        if (r_state == S_SCAN) begin
            r_rd_act <= r_active[r_scan];
        end
        if (w_emit) begin
            r_out_data <= {w_active16, |(w_active16 & r_final)};
        end
    end

    `ASSERT_RST(a_mem_we_state,
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_ADD_WR),
        "memory written outside clear or edge update")
    `ASSERT_RST(a_rd_vld_scan,
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_SCAN_DONE),
        "scan read data outside a scan")
    `ASSERT_RST(a_scan_idle,
        (r_state == S_IDLE) |-> (r_scan == '0),
        "scan counter not zero between words")
    `ASSERT_RST(a_emit_reload,
        w_emit |=> (r_active == $past(w_start_hot)),
        "active set not reloaded after end of word")
    `ASSERT_ALWAYS(a_no_take_clear,
        (i_rst_n && r_state == S_CLEAR) |-> !s_axis_tready,
        "input taken during memory clear")

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the NFA word acceptor. A scoreboard class keeps its
// own transition store, active set and registers, predicts the verdict of
// every end-of-word and checks each result word in order. A directed run
// covers the corner cases; random phases then build automata over small
// symbol pools and feed words through them under varying back-pressure.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic        accepted;
    logic [15:0] live_set;
} t_verdict;

class acceptor_scoreboard;
    logic [15:0] dest_mask [16][256];
    logic [15:0] active_set;
    logic [3:0]  start_state;
    logic [15:0] final_mask;
    t_verdict    verdicts[$];
    int          failures;

    function void reset_model();
        for (int s = 0; s < 16; s++) begin
            for (int c = 0; c < 256; c++) begin
                dest_mask[s][c] = '0;
            end
        end
        start_state = '0;
        final_mask  = '0;
        active_set  = 16'h0001;
        failures    = 0;
        verdicts.delete();
    endfunction

    function void write_reg(nfa_pkg::t_cfg_idx idx, logic [15:0] data);
        if (idx == nfa_pkg::CFG_START_STATE) begin
            start_state = data[3:0];
            active_set  = 16'h0001 << data[3:0];
        end else begin
            final_mask = data;
        end
    endfunction

    // Advance the model by one accepted input word.
    function void note_word(nfa_pkg::t_cmd cmd, logic [3:0] from_st, logic [3:0] to_st,
                            logic [7:0] sym);
        logic [15:0] next_set;
        t_verdict    v;
        case (cmd)
            nfa_pkg::CMD_ADD_EDGE: begin
                dest_mask[from_st][sym][to_st] = 1'b1;
            end
            nfa_pkg::CMD_SYMBOL: begin
                next_set = '0;
                for (int s = 0; s < 16; s++) begin
                    if (active_set[s]) next_set |= dest_mask[s][sym];
                end
                active_set = next_set;
            end
            nfa_pkg::CMD_END_WORD: begin
                v.accepted = |(active_set & final_mask);
                v.live_set = active_set;
                verdicts   = {verdicts, v};
                active_set = 16'h0001 << start_state;
            end
            default: ;
        endcase
    endfunction

    function void note_failure(string msg);
        if (failures < 10) $display("%s", msg);
        failures++;
    endfunction

    function void check_result(logic [nfa_pkg::M_TDATA_W-1:0] tdata);
        t_verdict v;
        if (verdicts.size() == 0) begin
            note_failure($sformatf("unexpected result word %h", tdata));
        end else begin
            v = verdicts.pop_front();
            if (tdata[0] !== v.accepted || tdata[16:1] !== v.live_set) begin
                note_failure($sformatf("mismatch: exp acc=%0d set=%h, got acc=%0d set=%h",
                                       v.accepted, v.live_set, tdata[0], tdata[16:1]));
            end
        end
    endfunction

    function void finish_check();
        if (verdicts.size() != 0) begin
            note_failure($sformatf("%0d verdicts never arrived", verdicts.size()));
            failures += verdicts.size() - 1;
        end
    endfunction
endclass

module tb_top;
    import nfa_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 230;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;  // from[3:0] to[7:4] symbol[15:8]
    logic [S_TUSER_W-1:0]  s_axis_tuser;  // command[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;  // accepted[0] active_set[16:1]

    int tx_idle_pct;
    int rx_idle_pct;

    acceptor_scoreboard sb;

    nfa_word_acceptor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Called and returns at a falling edge.
    task automatic push_word(t_cmd cmd, logic [3:0] from_st, logic [3:0] to_st,
                             logic [7:0] sym);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sym, to_st, from_st};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(cmd, from_st, to_st, sym);
        @(negedge i_clk);
    endtask

    // Edges and symbols give no result, so the drain covers a scan in flight.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.verdicts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [15:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic run_directed();
        set_reg(CFG_START_STATE, 16'h0000);
        set_reg(CFG_FINAL_MASK, 16'h8001);
        push_word(CMD_ADD_EDGE, 4'd0, 4'd15, 8'h00);
        push_word(CMD_ADD_EDGE, 4'd15, 4'd0, 8'hFF);
        push_word(CMD_ADD_EDGE, 4'd15, 4'd0, 8'hFF);   // duplicate edge
        push_word(CMD_ADD_EDGE, 4'd0, 4'd3, 8'h00);
        push_word(CMD_RSVD, 4'hF, 4'hF, 8'hFF);        // ignored command
        push_word(CMD_SYMBOL, 4'd0, 4'd0, 8'h00);
        push_word(CMD_SYMBOL, 4'hF, 4'hF, 8'hFF);
        push_word(CMD_END_WORD, 4'd0, 4'd0, 8'h00);
        push_word(CMD_SYMBOL, 4'd0, 4'd0, 8'h00);
        push_word(CMD_END_WORD, 4'hF, 4'hF, 8'hFF);
        // dead set stays dead
        push_word(CMD_SYMBOL, 4'd0, 4'd0, 8'h55);
        push_word(CMD_SYMBOL, 4'd0, 4'd0, 8'h00);
        push_word(CMD_END_WORD, 4'd0, 4'd0, 8'h00);
        // edge added mid-word is seen by the next symbol
        push_word(CMD_SYMBOL, 4'd0, 4'd0, 8'h00);
        push_word(CMD_ADD_EDGE, 4'd3, 4'd7, 8'h80);
        push_word(CMD_SYMBOL, 4'd0, 4'd0, 8'h80);
        push_word(CMD_END_WORD, 4'd0, 4'd0, 8'h00);
        // start write abandons the word in progress
        push_word(CMD_SYMBOL, 4'd0, 4'd0, 8'h00);
        set_reg(CFG_START_STATE, 16'h000F);
        push_word(CMD_END_WORD, 4'd0, 4'd0, 8'h00);
        set_reg(CFG_FINAL_MASK, 16'h0000);
        push_word(CMD_END_WORD, 4'd0, 4'd0, 8'h00);
        set_reg(CFG_START_STATE, 16'hFFF5);            // upper bits ignored
        push_word(CMD_END_WORD, 4'd0, 4'd0, 8'h00);
    endtask

    // Mostly automaton building and words over a small symbol pool.
    task automatic run_phase(logic [3:0] start_st, int n_items);
        logic [7:0] pool [4];
        int         count;
        int         pick;
        int         len;
        logic [3:0] from_st;
        logic [7:0] sym;
        for (int k = 0; k < 4; k++) pool[k] = 8'($urandom_range(255));
        count = 0;
        while (count < n_items) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                from_st = ($urandom_range(3) == 0) ? start_st : 4'($urandom_range(15));
                sym = ($urandom_range(99) < 85) ? pool[$urandom_range(3)]
                                                : 8'($urandom_range(255));
                push_word(CMD_ADD_EDGE, from_st, 4'($urandom_range(15)), sym);
                count++;
            end else if (pick < 88) begin
                len = $urandom_range(6);
                for (int k = 0; k < len; k++) begin
                    sym = ($urandom_range(99) < 90) ? pool[$urandom_range(3)]
                                                    : 8'($urandom_range(255));
                    push_word(CMD_SYMBOL, 4'($urandom_range(15)), 4'($urandom_range(15)), sym);
                end
                push_word(CMD_END_WORD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
                count += len + 1;
            end else if (pick < 94) begin
                push_word(CMD_SYMBOL, 4'($urandom_range(15)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
                count++;
            end else begin
                push_word(CMD_RSVD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        logic [3:0]  start_st;
        logic [15:0] mask;
        sb = new();
        sb.reset_model();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 20;
        rx_idle_pct   = 48;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin start_st = 4'd0;  mask = 16'hFFFF; end
                1: begin start_st = 4'd15; mask = 16'h0000; end
                3: begin start_st = 4'd15; mask = 16'h8000; end
                4: begin start_st = 4'd0;  mask = 16'h0001; end
                default: begin
                    start_st = 4'($urandom_range(15));
                    mask     = 16'($urandom_range(16'hFFFF));
                end
            endcase
            if (p < 2) begin
                tx_idle_pct = 20;
                rx_idle_pct = 48;
            end else if (p < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 20;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            set_reg(CFG_START_STATE, {12'($urandom_range(12'hFFF)), start_st});
            set_reg(CFG_FINAL_MASK, mask);
            run_phase(start_st, PHASE_ITEMS);
        end

        wait_idle();
        sb.finish_check();
        if (sb.failures == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
